[hw/rtl/gcp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, character codes and status codes of the G-code line parser.
package gcp_pkg;

   localparam int LETTER_W = 7;
   localparam int MANT_W   = 32;
   localparam int DEC_W    = 8;
   localparam int ENTRY_W  = LETTER_W + MANT_W + DEC_W;
   localparam int RSP_W    = 64;

   localparam logic [MANT_W-1:0] MAG_MAX = 32'h7FFF_FFFF;
   localparam logic [DEC_W-1:0]  DEC_MAX = 8'hFF;

   typedef logic [3:0] status_type;

   localparam status_type ST_OK_END       = 4'd0;
   localparam status_type ST_OK_TERM      = 4'd1;
   localparam status_type ST_ERR_SIGN     = 4'd2;
   localparam status_type ST_ERR_DOT      = 4'd3;
   localparam status_type ST_ERR_EARLY    = 4'd4;
   localparam status_type ST_ERR_ILLEGAL  = 4'd5;
   localparam status_type ST_ERR_LATE_N   = 4'd6;
   localparam status_type ST_ERR_SECOND   = 4'd7;
   localparam status_type ST_ERR_OVERFLOW = 4'd8;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_Z     = 8'h5A;

   typedef struct packed {
      logic take;
      logic flush;
      logic fetch;
      logic next;
      logic finish;
   } gcp_cmd_type;

   typedef struct packed {
      logic emit;
      logic single;
      logic last;
   } gcp_stat_type;

endpackage

[hw/rtl/gcp_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module gcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/gcp_datapath.sv]
`timescale 1ns / 1ps
// Character parsing state, working entry, entry store and result assembly.
module gcp_datapath import gcp_pkg::*; #(
   parameter int PARAM_CAPACITY = 16,
   parameter int LINE_LIMIT     = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  gcp_cmd_type      cmd,
   output gcp_stat_type     stat,
   input  logic [7:0]       req_char,
   input  logic             req_eob,
   output logic [RSP_W-1:0] rsp_data,
   output logic             rsp_last
);

   localparam int IDX_W = PARAM_CAPACITY > 1 ? $clog2(PARAM_CAPACITY) : 1;

   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [IDX_W-1:0]    rd_ff, rd_in;
   logic                als_ff, als_in;
   logic                sign_ff, sign_in;
   logic                neg_ff, neg_in;
   logic                dot_ff, dot_in;
   logic                num_ff, num_in;
   logic [7:0]          count_ff, count_in;
   logic                disc_ff, disc_in;
   logic                eobp_ff, eobp_in;
   logic [LETTER_W-1:0] let_ff, let_in;
   logic [MANT_W-1:0]   mant_ff, mant_in;
   logic [DEC_W-1:0]    dec_ff, dec_in;
   logic                rsingle_ff, rsingle_in;
   status_type          rstat_ff, rstat_in;
   logic [3:0]          reidx_ff, reidx_in;

   logic                ev_emit, ev_single, ev_err, ev_term, open_next;
   status_type          ev_status;
   logic [IDX_W:0]      cur_plus;
   logic [35:0]         prod;
   logic [3:0]          digit;
   logic                ram_we, ram_re;
   logic [IDX_W-1:0]    ram_raddr;
   logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
   logic [MANT_W-1:0]   wr_mant;
   logic [7:0]          cur8, rd8;
   logic [6:0]          count7;

   assign cur_plus = {1'b0, cur_ff} + (IDX_W+1)'(1);
   assign digit    = 4'(req_char - CH_0);
   assign prod     = ({4'b0, mant_ff} << 3) + ({4'b0, mant_ff} << 1) + 36'(digit);
   assign cur8     = 8'(cur_ff);
   assign rd8      = 8'(rd_ff);
   assign count7   = 7'(cur_ff) + 7'd1;

   always_comb begin
      cur_in     = cur_ff;
      rd_in      = rd_ff;
      als_in     = als_ff;
      sign_in    = sign_ff;
      neg_in     = neg_ff;
      dot_in     = dot_ff;
      num_in     = num_ff;
      count_in   = count_ff;
      disc_in    = disc_ff;
      eobp_in    = eobp_ff;
      let_in     = let_ff;
      mant_in    = mant_ff;
      dec_in     = dec_ff;
      rsingle_in = rsingle_ff;
      rstat_in   = rstat_ff;
      reidx_in   = reidx_ff;
      ev_emit    = 1'b0;
      ev_single  = 1'b0;
      ev_err     = 1'b0;
      ev_term    = 1'b0;
      ev_status  = ST_OK_END;
      open_next  = 1'b0;

      if (cmd.take) begin
         if (req_eob) begin
            if (disc_ff) begin
               cur_in   = '0;
               als_in   = 1'b1;
               sign_in  = 1'b0;
               neg_in   = 1'b0;
               dot_in   = 1'b0;
               num_in   = 1'b0;
               count_in = '0;
               disc_in  = 1'b0;
            end else begin
               ev_emit   = 1'b1;
               ev_single = als_ff;
               eobp_in   = 1'b1;
            end
         end else if (!disc_ff) begin
            if (req_char == CH_SPACE || req_char == CH_TAB) begin
               ev_err = 1'b0;
            end else if (req_char == CH_CR || req_char == CH_LF || req_char == CH_SEMI ||
                         req_char == CH_STAR || req_char == CH_LPAR ||
                         req_char == CH_PCT || req_char == CH_SLASH) begin
               ev_term   = 1'b1;
               ev_status = ST_OK_TERM;
            end else if (req_char == CH_N) begin
               if (!als_ff) begin
                  ev_err    = 1'b1;
                  ev_status = ST_ERR_LATE_N;
               end
            end else if (req_char == CH_G || req_char == CH_M) begin
               if (!als_ff) begin
                  ev_err    = 1'b1;
                  ev_status = ST_ERR_SECOND;
               end else begin
                  als_in  = 1'b0;
                  cur_in  = '0;
                  let_in  = req_char[LETTER_W-1:0];
                  mant_in = '0;
                  dec_in  = '0;
               end
            end else if (req_char == CH_PLUS || req_char == CH_MINUS) begin
               if (als_ff || sign_ff || num_ff) begin
                  ev_err    = 1'b1;
                  ev_status = ST_ERR_SIGN;
               end else begin
                  sign_in = 1'b1;
                  neg_in  = (req_char == CH_MINUS);
                  num_in  = 1'b1;
               end
            end else if (req_char == CH_DOT) begin
               if (als_ff || dot_ff) begin
                  ev_err    = 1'b1;
                  ev_status = ST_ERR_DOT;
               end else begin
                  sign_in = 1'b1;
                  dot_in  = 1'b1;
                  num_in  = 1'b1;
               end
            end else if (req_char >= CH_0 && req_char <= CH_9) begin
               if (!als_ff) begin
                  mant_in = (prod > 36'(MAG_MAX)) ? MAG_MAX : prod[MANT_W-1:0];
                  sign_in = 1'b1;
                  num_in  = 1'b1;
                  if (dot_ff && dec_ff != DEC_MAX) begin
                     dec_in = dec_ff + DEC_W'(1);
                  end
               end
            end else if (req_char >= CH_A && req_char <= CH_Z) begin
               if (als_ff) begin
                  ev_err    = 1'b1;
                  ev_status = ST_ERR_EARLY;
               end else if (cur_plus >= (IDX_W+1)'(PARAM_CAPACITY)) begin
                  ev_err    = 1'b1;
                  ev_status = ST_ERR_OVERFLOW;
               end else begin
                  open_next = 1'b1;
                  sign_in   = 1'b0;
                  neg_in    = 1'b0;
                  dot_in    = 1'b0;
                  num_in    = 1'b0;
                  cur_in    = cur_plus[IDX_W-1:0];
                  let_in    = req_char[LETTER_W-1:0];
                  mant_in   = '0;
                  dec_in    = '0;
               end
            end else begin
               ev_err    = 1'b1;
               ev_status = ST_ERR_ILLEGAL;
            end

            if (ev_err) begin
               ev_emit   = 1'b1;
               ev_single = 1'b1;
            end else if (ev_term) begin
               ev_emit   = 1'b1;
               ev_single = als_ff;
            end else begin
               count_in = count_ff + 8'd1;
               if (count_in >= 8'(LINE_LIMIT)) begin
                  ev_emit   = 1'b1;
                  ev_single = als_in;
                  ev_status = ST_OK_END;
               end
            end
            if (ev_emit) begin
               disc_in = 1'b1;
            end
         end

         if (ev_emit) begin
            rsingle_in = ev_single;
            rstat_in   = ev_status;
            reidx_in   = ev_err ? cur8[3:0] : 4'd0;
         end
      end

      if (cmd.fetch) begin
         rd_in = '0;
      end else if (cmd.next) begin
         rd_in = rd_ff + IDX_W'(1);
      end

      if (cmd.finish && eobp_ff) begin
         cur_in   = '0;
         als_in   = 1'b1;
         sign_in  = 1'b0;
         neg_in   = 1'b0;
         dot_in   = 1'b0;
         num_in   = 1'b0;
         count_in = '0;
         disc_in  = 1'b0;
         eobp_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         als_ff   <= 1'b1;
         sign_ff  <= 1'b0;
         neg_ff   <= 1'b0;
         dot_ff   <= 1'b0;
         num_ff   <= 1'b0;
         count_ff <= '0;
         disc_ff  <= 1'b0;
         eobp_ff  <= 1'b0;
      end else begin
         cur_ff   <= cur_in;
         als_ff   <= als_in;
         sign_ff  <= sign_in;
         neg_ff   <= neg_in;
         dot_ff   <= dot_in;
         num_ff   <= num_in;
         count_ff <= count_in;
         disc_ff  <= disc_in;
         eobp_ff  <= eobp_in;
      end
      rd_ff      <= rd_in;
      let_ff     <= let_in;
      mant_ff    <= mant_in;
      dec_ff     <= dec_in;
      rsingle_ff <= rsingle_in;
      rstat_ff   <= rstat_in;
      reidx_ff   <= reidx_in;
   end

   assign wr_mant   = neg_ff ? (MANT_W'(0) - mant_ff) : mant_ff;
   assign ram_we    = cmd.flush || open_next;
   assign ram_wdata = {let_ff, wr_mant, dec_ff};
   assign ram_re    = cmd.fetch || cmd.next;
   assign ram_raddr = cmd.fetch ? IDX_W'(0) : (rd_ff + IDX_W'(1));

   gcp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PARAM_CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (cur_ff),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      if (rsingle_ff) begin
         rsp_data = {DEC_W'(0), MANT_W'(0), LETTER_W'(0), 4'd0, 5'd0, reidx_ff, rstat_ff};
         rsp_last = 1'b1;
      end else begin
         rsp_data = {ram_rdata[DEC_W-1:0],
                     ram_rdata[DEC_W +: MANT_W],
                     ram_rdata[DEC_W+MANT_W +: LETTER_W],
                     rd8[3:0], count7[4:0], 4'd0, rstat_ff};
         rsp_last = (rd_ff == cur_ff);
      end
   end

   assign stat.emit   = ev_emit;
   assign stat.single = ev_single;
   assign stat.last   = (rd_ff == cur_ff);

endmodule

[hw/rtl/gcp_controller.sv]
`timescale 1ns / 1ps
// Sequencer for character intake, entry write-back and result delivery.
module gcp_controller import gcp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output gcp_cmd_type  cmd,
   input  gcp_stat_type stat
);

   typedef enum logic [2:0] {
      S_RUN,
      S_FLUSH,
      S_FETCH,
      S_SEND,
      S_SINGLE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_fire;

   assign req_tready = (state_ff == S_RUN);
   assign rsp_tvalid = (state_ff == S_SEND) || (state_ff == S_SINGLE);
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      unique case (state_ff)
         S_RUN: begin
            cmd.take = req_tvalid;
            if (req_tvalid && stat.emit) begin
               state_in = stat.single ? S_SINGLE : S_FLUSH;
            end
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = S_FETCH;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_SEND;
         end
         S_SEND: begin
            if (rsp_fire) begin
               if (stat.last) begin
                  cmd.finish = 1'b1;
                  state_in   = S_RUN;
               end else begin
                  cmd.next = 1'b1;
               end
            end
         end
         S_SINGLE: begin
            if (rsp_fire) begin
               cmd.finish = 1'b1;
               state_in   = S_RUN;
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/gcode_line_parser.sv]
`timescale 1ns / 1ps
// Top level of the G-code line parser: controller, datapath and port packing.
//
// Feed one line character per transaction on the req_ channel; req_tlast marks
// an end-of-buffer transaction that closes the line and rearms the parser.
// Results leave on the rsp_ channel, one per parsed entry (command first),
// or a single result for an empty line or an error; rsp_tlast marks the
// final result of a line.
// A character that does not close a line is taken with req_tready staying high.
// A line that closes with entries writes back the open entry, reads the entry
// store and then gives one result per cycle while rsp_tready is high.
// Empty-line and error results show in the cycle after the closing transaction.
// req_tready is low while results of a line are pending; a stalled rsp_
// channel holds the current result and the parser until it is taken.
// Reset returns the parser to the start of a line; the entry store keeps no
// reset value, every entry is written before it is read.
module gcode_line_parser import gcp_pkg::*; #(
   parameter int PARAM_CAPACITY = 16,
   parameter int LINE_LIMIT     = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic        req_tlast,   // end_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] status, [7:4] error_index, [12:8] param_count, [16:13] entry_index,
   // [23:17] letter, [55:24] mantissa, [63:56] decimals
   output logic [63:0] rsp_tdata,
   output logic        rsp_tlast    // last
);

   gcp_cmd_type  cmd;
   gcp_stat_type stat;

   gcp_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   gcp_datapath #(
      .PARAM_CAPACITY (PARAM_CAPACITY),
      .LINE_LIMIT     (LINE_LIMIT)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_char (req_tdata),
      .req_eob  (req_tlast),
      .rsp_data (rsp_tdata),
      .rsp_last (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("intake and result delivery active together");

   a_rearm_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("parser not ready after final result of a line");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3:0] >= ST_ERR_SIGN) |->
      (rsp_tlast && rsp_tdata[12:8] == 5'd0))
      else $error("error result is not a single final result");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");
`endif

endmodule
